>>> rtl/core/wpmq_pkg.sv
// ----------------------------------------------------------------------------
// wpmq_pkg
// Shared types and constants of the weighted priority message queue.
// ----------------------------------------------------------------------------
package wpmq_pkg;

  localparam int unsigned PRI_W   = 4;
  localparam int unsigned HELD_W  = 10;
  localparam int unsigned LIMIT_W = 10;
  localparam int unsigned CFG_W   = 10;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPRI = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_BADPRI = 2'd2
  } op_e;

  typedef enum logic {
    CFG_TOTAL_LIMIT   = 1'b0,
    CFG_LEVELS_IN_USE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e              op;
    logic [PRI_W-1:0] lv;
  } cmd_t;

endpackage

>>> rtl/core/wpmq_if.sv
// ----------------------------------------------------------------------------
// wpmq_in_if / wpmq_out_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface wpmq_in_if #(
  parameter int unsigned HANDLE_BITS = 32
);
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [wpmq_pkg::PRI_W-1:0] priority_req;
  logic [HANDLE_BITS-1:0]    msg_handle;

  modport source (output valid, func, priority_req, msg_handle, input ready);
  modport sink   (input valid, func, priority_req, msg_handle, output ready);
endinterface

interface wpmq_out_if #(
  parameter int unsigned HANDLE_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [HANDLE_BITS-1:0]      out_handle;
  logic [1:0]                  status;
  logic [wpmq_pkg::PRI_W-1:0]  served_level;
  logic [wpmq_pkg::HELD_W-1:0] held_count;

  modport source (output valid, out_handle, status, served_level, held_count, input ready);
  modport sink   (input valid, out_handle, status, served_level, held_count, output ready);
endinterface

>>> rtl/core/wpmq_front.sv
// ----------------------------------------------------------------------------
// wpmq_front
// Accept and classify request words into a two-entry command queue.
// ----------------------------------------------------------------------------
module wpmq_front #(
  parameter int unsigned LEVELS      = 8,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [wpmq_pkg::PRI_W-1:0]  priority_req_i,
  input  logic [HANDLE_BITS-1:0]      msg_handle_i,
  input  logic [wpmq_pkg::PRI_W-1:0]  levels_in_use_i,
  output logic                        cmd_valid_o,
  output wpmq_pkg::cmd_t              cmd_o,
  output logic [HANDLE_BITS-1:0]      cmd_handle_o,
  input  logic                        cmd_pop_i
);

  wpmq_pkg::cmd_t         ent_q [2];
  logic [HANDLE_BITS-1:0] hdl_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  wpmq_pkg::cmd_t         cls;
  logic                   push;

  always_comb begin
    cls.lv = wpmq_pkg::PRI_W'(priority_req_i - wpmq_pkg::PRI_W'(1));
    if (func_i) begin
      cls.op = wpmq_pkg::OP_POP;
    end else if (priority_req_i == '0 || priority_req_i > levels_in_use_i ||
                 32'(priority_req_i) > LEVELS) begin
      cls.op = wpmq_pkg::OP_BADPRI;
    end else begin
      cls.op = wpmq_pkg::OP_PUSH;
    end
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign cmd_valid_o  = (cnt_q != 2'd0);
  assign cmd_o        = ent_q[rd_ptr_q];
  assign cmd_handle_o = hdl_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cls;
      hdl_q[wr_ptr_q] <= msg_handle_i;
    end
  end

endmodule

>>> rtl/core/wpmq_back.sv
// ----------------------------------------------------------------------------
// wpmq_back
// Execute commands: level FIFOs, weighted level choice and response register.
// ----------------------------------------------------------------------------
module wpmq_back #(
  parameter int unsigned LEVELS      = 8,
  parameter int unsigned LEVEL_DEPTH = 64,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  wpmq_pkg::cmd_t                cmd_i,
  input  logic [HANDLE_BITS-1:0]        cmd_handle_i,
  output logic                          cmd_pop_o,
  input  logic [wpmq_pkg::LIMIT_W-1:0]  total_limit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [HANDLE_BITS-1:0]        out_handle_o,
  output logic [1:0]                    status_o,
  output logic [wpmq_pkg::PRI_W-1:0]    served_level_o,
  output logic [wpmq_pkg::HELD_W-1:0]   held_count_o
);

  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned PW = $clog2(LEVEL_DEPTH);
  localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned KW = $clog2(LEVELS + 1);
  localparam int unsigned SD = LEVELS * LEVEL_DEPTH;
  localparam int unsigned AW = $clog2(SD);

  typedef enum logic [1:0] {
    S_DISPATCH = 2'b01,
    S_RESPOND  = 2'b10
  } state_e;

  state_e                        state_q, state_d;
  logic [PW-1:0]                 head_q   [LEVELS];
  logic [PW-1:0]                 tail_q   [LEVELS];
  logic [CW-1:0]                 count_q  [LEVELS];
  logic [KW-1:0]                 credit_q [LEVELS];
  logic [LW-1:0]                 start_q;
  logic [wpmq_pkg::HELD_W-1:0]   total_q;
  logic [HANDLE_BITS-1:0]        store [SD];
  logic [HANDLE_BITS-1:0]        rdata_q;
  logic                          take_q;
  wpmq_pkg::status_e             res_status_q;
  logic [wpmq_pkg::PRI_W-1:0]    res_level_q;
  logic                          out_valid_q;
  logic [HANDLE_BITS-1:0]        out_handle_q;
  logic [1:0]                    out_status_q;
  logic [wpmq_pkg::PRI_W-1:0]    out_level_q;
  logic [wpmq_pkg::HELD_W-1:0]   out_held_q;

  logic                          fire;
  logic [LEVELS-1:0]             nonempty;
  logic [LEVELS-1:0]             exhausted;
  logic [LEVELS-1:0]             clear_mask;
  logic [LW-1:0]                 s_lv;
  logic [LW-1:0]                 srv_lv;
  logic                          charge;
  logic [LW-1:0]                 push_lv;
  logic                          push_full;

  function automatic logic [LW-1:0] lv_down(input logic [LW-1:0] a, input int k);
    int t;
    t = int'(a) - k;
    if (t < 0) begin
      t = t + int'(LEVELS);
    end
    return LW'(t);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] lv,
                                           input logic [PW-1:0] p);
    return AW'(int'(lv) * int'(LEVEL_DEPTH) + int'(p));
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (32'(p) == LEVEL_DEPTH - 1) ? '0 : PW'(p + PW'(1));
  endfunction

  assign fire      = (state_q == S_DISPATCH) && cmd_valid_i &&
                     (!out_valid_q || out_ready_i);
  assign cmd_pop_o = fire;
  assign push_lv   = cmd_i.lv[LW-1:0];
  assign push_full = (total_q >= total_limit_i) ||
                     (32'(count_q[push_lv]) == LEVEL_DEPTH);

  always_comb begin
    logic found;
    logic [LW-1:0] idx;
    for (int l = 0; l < LEVELS; l++) begin
      nonempty[l]  = (count_q[l] != '0);
      exhausted[l] = (credit_q[l] >= KW'(l + 1));
    end
    found = 1'b0;
    s_lv  = start_q;
    for (int k = 0; k < LEVELS; k++) begin
      idx = lv_down(start_q, k);
      if (!found && nonempty[idx]) begin
        found = 1'b1;
        s_lv  = idx;
      end
    end
    clear_mask = '0;
    srv_lv     = s_lv;
    charge     = 1'b1;
    if (exhausted[s_lv]) begin
      if (32'(count_q[s_lv]) == 32'(total_q)) begin
        charge = 1'b0;
      end else begin
        clear_mask[s_lv] = 1'b1;
        found = 1'b0;
        for (int k = 1; k < LEVELS; k++) begin
          idx = lv_down(s_lv, k);
          if (!found) begin
            if (nonempty[idx] && !exhausted[idx]) begin
              found  = 1'b1;
              srv_lv = idx;
            end else if (exhausted[idx]) begin
              clear_mask[idx] = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_DISPATCH: if (fire) state_d = S_RESPOND;
      S_RESPOND:  state_d = S_DISPATCH;
      default:    state_d = S_DISPATCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_DISPATCH;
      start_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l]   <= '0;
        tail_q[l]   <= '0;
        count_q[l]  <= '0;
        credit_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_RESPOND) begin
        out_valid_q <= 1'b1;
      end
      if (fire) begin
        unique case (cmd_i.op)
          wpmq_pkg::OP_PUSH: begin
            if (!push_full) begin
              tail_q[push_lv]  <= ptr_inc(tail_q[push_lv]);
              count_q[push_lv] <= count_q[push_lv] + CW'(1);
              total_q          <= total_q + wpmq_pkg::HELD_W'(1);
              if (push_lv > start_q) begin
                start_q <= push_lv;
              end
            end
          end
          wpmq_pkg::OP_POP: begin
            if (total_q != '0) begin
              start_q         <= s_lv;
              head_q[srv_lv]  <= ptr_inc(head_q[srv_lv]);
              count_q[srv_lv] <= count_q[srv_lv] - CW'(1);
              total_q         <= total_q - wpmq_pkg::HELD_W'(1);
              for (int l = 0; l < LEVELS; l++) begin
                if (charge && LW'(l) == srv_lv) begin
                  credit_q[l] <= (clear_mask[l] ? '0 : credit_q[l]) + KW'(1);
                end else if (clear_mask[l]) begin
                  credit_q[l] <= '0;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      take_q       <= 1'b0;
      res_level_q  <= '0;
      res_status_q <= wpmq_pkg::ST_OK;
      unique case (cmd_i.op)
        wpmq_pkg::OP_PUSH: begin
          if (push_full) begin
            res_status_q <= wpmq_pkg::ST_FULL;
          end else begin
            store[addr_of(push_lv, tail_q[push_lv])] <= cmd_handle_i;
          end
        end
        wpmq_pkg::OP_POP: begin
          if (total_q == '0) begin
            res_status_q <= wpmq_pkg::ST_EMPTY;
          end else begin
            take_q      <= 1'b1;
            res_level_q <= wpmq_pkg::PRI_W'(32'(srv_lv) + 32'd1);
            rdata_q     <= store[addr_of(srv_lv, head_q[srv_lv])];
          end
        end
        default: res_status_q <= wpmq_pkg::ST_BADPRI;
      endcase
    end
    if (state_q == S_RESPOND) begin
      out_handle_q <= take_q ? rdata_q : '0;
      out_status_q <= res_status_q;
      out_level_q  <= res_level_q;
      out_held_q   <= total_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_handle_o   = out_handle_q;
  assign status_o       = out_status_q;
  assign served_level_o = out_level_q;
  assign held_count_o   = out_held_q;

endmodule

>>> rtl/core/weighted_priority_message_queue_unit.sv
// ----------------------------------------------------------------------------
// weighted_priority_message_queue_unit
// Per-level message FIFOs served by weighted round robin.
// ----------------------------------------------------------------------------
// Request words enter on in_if: func 0 pushes msg_handle at level
// priority_req, func 1 pops the next handle. Every request gives exactly one
// response word on out_if with the handle, a status code, the level served
// and the number of handles held afterwards.
// A request passes through the dispatch and respond states of the execute
// unit: dispatch chooses the level and accesses the handle store, respond
// loads the response register. The unit takes no new command while in
// respond, nor while an earlier response waits and out_if.ready is low.
// A two-entry command queue keeps accepting words while a response waits;
// when the receiver stalls, the queue fills and in_if.ready drops.
// Reset clears all level pointers, counts and credits; the limit register
// returns to 512 and the level register to 8. Handle store contents are
// undefined until written. Write configuration only while idle.
// ----------------------------------------------------------------------------
module weighted_priority_message_queue_unit #(
  parameter int unsigned LEVELS      = 8,
  parameter int unsigned LEVEL_DEPTH = 64,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [wpmq_pkg::CFG_W-1:0]   cfg_data_i,
  wpmq_in_if.sink                      in_if,
  wpmq_out_if.source                   out_if
);

  logic [wpmq_pkg::LIMIT_W-1:0] total_limit_q;
  logic [wpmq_pkg::PRI_W-1:0]   levels_in_use_q;
  logic                         cmd_valid;
  wpmq_pkg::cmd_t               cmd;
  logic [HANDLE_BITS-1:0]       cmd_handle;
  logic                         cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_limit_q   <= wpmq_pkg::LIMIT_W'(512);
      levels_in_use_q <= wpmq_pkg::PRI_W'(8);
    end else if (cfg_we_i) begin
      case (wpmq_pkg::cfg_idx_e'(cfg_idx_i))
        wpmq_pkg::CFG_TOTAL_LIMIT:   total_limit_q   <= cfg_data_i[wpmq_pkg::LIMIT_W-1:0];
        wpmq_pkg::CFG_LEVELS_IN_USE: levels_in_use_q <= cfg_data_i[wpmq_pkg::PRI_W-1:0];
        default: ;
      endcase
    end
  end

  wpmq_front #(
    .LEVELS      (LEVELS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_if.valid),
    .in_ready_o      (in_if.ready),
    .func_i          (in_if.func),
    .priority_req_i  (in_if.priority_req),
    .msg_handle_i    (in_if.msg_handle),
    .levels_in_use_i (levels_in_use_q),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_handle_o    (cmd_handle),
    .cmd_pop_i       (cmd_pop)
  );

  wpmq_back #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_handle_i   (cmd_handle),
    .cmd_pop_o      (cmd_pop),
    .total_limit_i  (total_limit_q),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .out_handle_o   (out_if.out_handle),
    .status_o       (out_if.status),
    .served_level_o (out_if.served_level),
    .held_count_o   (out_if.held_count)
  );

endmodule
